FILE: rtl/m3inv_pkg.sv
package m3inv_pkg;

	localparam int IN_FRAC_BITS = 8;
	localparam int EW = 16;                   // element width
	localparam int PW = 2 * EW;               // product width
	localparam int CW = PW + 1;               // signed cofactor width
	localparam int MW = PW;                   // cofactor magnitude width
	localparam int DPW = EW + CW;             // det term width
	localparam int DSW = DPW + 2;             // det sum width
	localparam int DETW = 49;
	localparam int DMW = DETW - 1;            // det magnitude width
	localparam int QW = 32;
	localparam int SHIFT = 16 + IN_FRAC_BITS;
	localparam int NW = MW + SHIFT;           // numerator width
	localparam int NLANE = 9;
	localparam int IN_TDATA_W = NLANE * EW;
	localparam int OUT_RAW_W = NLANE * QW + DETW;
	localparam int OUT_TDATA_W = ((OUT_RAW_W + 7) / 8) * 8;

	// element indexes (row*3+col) of the two products of each cofactor, c = a*b - x*y
	localparam int CA_X [NLANE] = '{4, 5, 3, 2, 0, 1, 1, 2, 0};
	localparam int CA_Y [NLANE] = '{8, 6, 7, 7, 8, 6, 5, 3, 4};
	localparam int CB_X [NLANE] = '{5, 3, 4, 1, 2, 0, 2, 0, 1};
	localparam int CB_Y [NLANE] = '{7, 8, 6, 8, 6, 7, 4, 5, 3};

	typedef struct packed {
		logic [DMW-1:0] rem;
		logic [QW-1:0]  num;
		logic [QW-1:0]  quo;
		logic           neg;
		logic           big;
	} lane_t;

	typedef struct packed {
		lane_t [NLANE-1:0] lane;
		logic [DMW-1:0]    dm;
		logic [DETW-1:0]   det;
		logic              sing;
	} div_t;

	// one restoring step, one quotient bit
	function automatic lane_t div_step(lane_t l, logic [DMW-1:0] dm);
		lane_t o;
		logic [DMW:0] r;
		logic ge;
		r = {l.rem, l.num[QW-1]};
		ge = (r >= {1'b0, dm});
		if (ge) begin
			r = r - {1'b0, dm};
		end
		o = l;
		o.rem = r[DMW-1:0];
		o.num = {l.num[QW-2:0], 1'b0};
		o.quo = {l.quo[QW-2:0], ge};
		return o;
	endfunction

endpackage

FILE: rtl/matrix3x3_inverse_top.sv
// channel  | dir | tdata fields (low bit up)                    | tuser
// s_*      | in  | a_00 a_01 a_02 a_10 a_11 a_12 a_20 a_21 a_22 | -
// m_*      | out | inv_00 .. inv_22, det_value, zero pad        | singular
//
// one matrix per cycle sustained while m_tready is high
// the datapath is a 32-stage restoring divider, one quotient bit per stage,
// nine lanes side by side, after four stages of multiply and cofactor logic
// arst_n clears all stage valid bits; data registers are not reset
// each stage holds only when it is full and the stage after it is blocked,
// so bubbles are squeezed out and a stall drops or repeats nothing
module matrix3x3_inverse_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [m3inv_pkg::IN_TDATA_W-1:0]  s_tdata,  // a_00 .. a_22, 16 bits each
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [m3inv_pkg::OUT_TDATA_W-1:0] m_tdata,  // inv_00 .. inv_22, det_value, pad
	output logic                              m_tuser   // singular
);
	import m3inv_pkg::*;

	localparam int NDIV = QW + 1;
	localparam int NST = 4 + NDIV + 1;
	localparam int OST = NST - 1;

	logic [NST-1:0] st_v;
	logic [NST:0]   en;

	logic signed [EW-1:0]  a_s1 [3];
	logic signed [PW-1:0]  pa_s1 [NLANE];
	logic signed [PW-1:0]  pb_s1 [NLANE];
	logic signed [EW-1:0]  a_s2 [3];
	logic signed [CW-1:0]  c_s2 [NLANE];
	logic signed [DPW-1:0] dp_s3 [3];
	logic signed [CW-1:0]  c_s3 [NLANE];
	logic [DETW-1:0]       det_s4;
	logic [MW-1:0]         cm_s4 [NLANE];
	logic                  cn_s4 [NLANE];
	div_t                  dv_s [NDIV];
	logic [QW-1:0]         inv_q [NLANE];
	logic [DETW-1:0]       det_q;
	logic                  sing_q;

	always_comb begin
		en[NST] = m_tready;
		for (int k = NST - 1; k >= 0; k--) begin
			en[k] = !st_v[k] || en[k+1];
		end
	end

	assign s_tready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_v <= '0;
		end else begin
			if (en[0]) begin
				st_v[0] <= s_tvalid;
			end
			for (int k = 1; k < NST; k++) begin
				if (en[k]) begin
					st_v[k] <= st_v[k-1];
				end
			end
		end
	end

	// s1: the eighteen 2x2 minor products
	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int e = 0; e < 3; e++) begin
				a_s1[e] <= s_tdata[e*EW +: EW];
			end
			for (int e = 0; e < NLANE; e++) begin
				pa_s1[e] <= $signed(s_tdata[CA_X[e]*EW +: EW]) *
					$signed(s_tdata[CA_Y[e]*EW +: EW]);
				pb_s1[e] <= $signed(s_tdata[CB_X[e]*EW +: EW]) *
					$signed(s_tdata[CB_Y[e]*EW +: EW]);
			end
		end
	end

	// s2: cofactors
	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int e = 0; e < NLANE; e++) begin
				c_s2[e] <= {pa_s1[e][PW-1], pa_s1[e]} - {pb_s1[e][PW-1], pb_s1[e]};
			end
			for (int e = 0; e < 3; e++) begin
				a_s2[e] <= a_s1[e];
			end
		end
	end

	// s3: first-row expansion terms
	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int e = 0; e < 3; e++) begin
				dp_s3[e] <= a_s2[e] * c_s2[e];
			end
			for (int e = 0; e < NLANE; e++) begin
				c_s3[e] <= c_s2[e];
			end
		end
	end

	// s4: determinant sum and cofactor magnitudes
	always_ff @(posedge clk) begin
		logic [DSW-1:0] sum;
		if (en[3]) begin
			sum = {{2{dp_s3[0][DPW-1]}}, dp_s3[0]} + {{2{dp_s3[1][DPW-1]}}, dp_s3[1]} +
				{{2{dp_s3[2][DPW-1]}}, dp_s3[2]};
			det_s4 <= sum[DETW-1:0];
			for (int e = 0; e < NLANE; e++) begin
				cn_s4[e] <= c_s3[e][CW-1];
				cm_s4[e] <= c_s3[e][CW-1] ? MW'(-c_s3[e]) : c_s3[e][MW-1:0];
			end
		end
	end

	// divider entry: lane i*3+j divides cofactor j*3+i; quotient >= 2^32 flagged big
	always_ff @(posedge clk) begin
		logic [DMW-1:0] dm;
		logic [NW-1:0]  n;
		logic [DMW-1:0] r0;
		int c;
		if (en[4]) begin
			dm = det_s4[DETW-1] ? DMW'(-det_s4) : det_s4[DMW-1:0];
			for (int l = 0; l < NLANE; l++) begin
				c = (l % 3) * 3 + (l / 3);
				n = {cm_s4[c], {SHIFT{1'b0}}};
				r0 = DMW'(n[NW-1:QW]);
				dv_s[0].lane[l].rem <= r0;
				dv_s[0].lane[l].num <= n[QW-1:0];
				dv_s[0].lane[l].quo <= '0;
				dv_s[0].lane[l].neg <= cn_s4[c] != det_s4[DETW-1];
				dv_s[0].lane[l].big <= r0 >= dm;
			end
			dv_s[0].dm <= dm;
			dv_s[0].det <= det_s4;
			dv_s[0].sing <= (det_s4 == '0);
		end
	end

	for (genvar k = 1; k < NDIV; k++) begin : g_div
		always_ff @(posedge clk) begin
			if (en[4+k]) begin
				for (int l = 0; l < NLANE; l++) begin
					dv_s[k].lane[l] <= div_step(dv_s[k-1].lane[l], dv_s[k-1].dm);
				end
				dv_s[k].dm <= dv_s[k-1].dm;
				dv_s[k].det <= dv_s[k-1].det;
				dv_s[k].sing <= dv_s[k-1].sing;
			end
		end
	end

	// output register: sign, saturation and zeroing of singular results
	always_ff @(posedge clk) begin
		lane_t l;
		if (en[OST]) begin
			for (int i = 0; i < NLANE; i++) begin
				l = dv_s[NDIV-1].lane[i];
				if (dv_s[NDIV-1].sing) begin
					inv_q[i] <= '0;
				end else if (l.neg) begin
					inv_q[i] <= (l.big || l.quo > {1'b1, {(QW-1){1'b0}}}) ?
						{1'b1, {(QW-1){1'b0}}} : QW'(-l.quo);
				end else begin
					inv_q[i] <= (l.big || l.quo[QW-1]) ? {1'b0, {(QW-1){1'b1}}} : l.quo;
				end
			end
			det_q <= dv_s[NDIV-1].det;
			sing_q <= dv_s[NDIV-1].sing;
		end
	end

	assign m_tvalid = st_v[OST];
	assign m_tuser = sing_q;
	always_comb begin
		m_tdata = '0;
		for (int i = 0; i < NLANE; i++) begin
			m_tdata[i*QW +: QW] = inv_q[i];
		end
		m_tdata[NLANE*QW +: DETW] = det_q;
	end

	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata[OUT_RAW_W-1:0] == '0))
		else $error("singular result with nonzero data");
	a_det_nz: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata[NLANE*QW +: DETW] != '0))
		else $error("zero determinant not flagged singular");
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> st_v[0])
		else $error("accepted transaction lost at first stage");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(st_v[4] && !en[5]) |=> (st_v[4] && $stable(dv_s[0])))
		else $error("stalled divider entry changed");

endmodule
